FILE: hw/rtl/bdbs_pkg.sv
// Shared types, widths and register codes for the best detection box selector.
`timescale 1ns / 1ps

package bdbs_pkg;

	localparam int CoordW   = 16;
	localparam int ScoreW   = 16;
	localparam int FrameW   = 13;
	localparam int WinW     = 12;
	localparam int EdgeW    = 15;
	localparam int CenterW  = 17;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_SCORE_THRESHOLD = 3'd0,
		REG_FRAME_WIDTH     = 3'd1,
		REG_FRAME_HEIGHT    = 3'd2,
		REG_WINDOW_LOW      = 3'd3,
		REG_WINDOW_HIGH     = 3'd4
	} cfg_reg_t;

	localparam logic [ScoreW-1:0] ThresholdReset = 16'd11468;
	localparam logic [FrameW-1:0] FrameWidthReset  = 13'd640;
	localparam logic [FrameW-1:0] FrameHeightReset = 13'd640;
	localparam logic [WinW-1:0]   WindowLowReset   = 12'd265;
	localparam logic [WinW-1:0]   WindowHighReset  = 12'd275;

	typedef struct packed {
		logic [ScoreW-1:0] score_threshold;
		logic [FrameW-1:0] frame_width;
		logic [FrameW-1:0] frame_height;
		logic [WinW-1:0]   window_low;
		logic [WinW-1:0]   window_high;
	} cfg_t;

	// Chosen box of a frame; found marks that any prediction passed
	typedef struct packed {
		logic              found;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [CoordW-1:0] w;
		logic [CoordW-1:0] h;
		logic [ScoreW-1:0] score;
	} box_t;

endpackage

FILE: hw/rtl/bdbs_if.sv
// Valid/ready channel interfaces for prediction and result words.
`timescale 1ns / 1ps

interface bdbs_pred_if;
	logic                          valid;
	logic                          ready;
	logic [bdbs_pkg::CoordW-1:0]   box_x;
	logic [bdbs_pkg::CoordW-1:0]   box_y;
	logic [bdbs_pkg::CoordW-1:0]   box_w;
	logic [bdbs_pkg::CoordW-1:0]   box_h;
	logic [bdbs_pkg::ScoreW-1:0]   score;
	logic                          last;

	modport source (output valid, box_x, box_y, box_w, box_h, score, last, input ready);
	modport sink   (input valid, box_x, box_y, box_w, box_h, score, last, output ready);
endinterface

interface bdbs_result_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 found;
	logic signed [bdbs_pkg::EdgeW-1:0]    left;
	logic signed [bdbs_pkg::EdgeW-1:0]    top;
	logic signed [bdbs_pkg::EdgeW-1:0]    right;
	logic signed [bdbs_pkg::EdgeW-1:0]    bottom;
	logic [bdbs_pkg::CenterW-1:0]         center_x_q4;
	logic [bdbs_pkg::CenterW-1:0]         center_y_q4;
	logic [bdbs_pkg::ScoreW-1:0]          best_score;
	logic                                 aligned;

	modport source (output valid, found, left, top, right, bottom, center_x_q4, center_y_q4,
		best_score, aligned, input ready);
	modport sink   (input valid, found, left, top, right, bottom, center_x_q4, center_y_q4,
		best_score, aligned, output ready);
endinterface

FILE: hw/rtl/bdbs_select.sv
// Running best-score selection over a frame and hand-off of the chosen box.
`timescale 1ns / 1ps

module bdbs_select (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdbs_pkg::cfg_t       cfg,
	bdbs_pred_if.sink            pred,
	output logic                 box_valid,
	output bdbs_pkg::box_t       box,
	input  logic                 box_ready
);

	bdbs_pkg::box_t kept_q;
	bdbs_pkg::box_t next_box;
	bdbs_pkg::box_t box_s1;
	logic           valid_s1;
	logic           take;
	logic           accept;

	// Keep a prediction above threshold that beats the one held so far
	always_comb begin
		take = (pred.score > cfg.score_threshold) &&
			(!kept_q.found || (pred.score > kept_q.score));
		if (take) begin
			next_box = '{found: 1'b1, x: pred.box_x, y: pred.box_y, w: pred.box_w,
				h: pred.box_h, score: pred.score};
		end else begin
			next_box = kept_q;
		end
	end

	assign pred.ready = !valid_s1 || box_ready;
	assign accept     = pred.valid && pred.ready;

	// Update the frame selection; clear it once the last word is in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= '0;
		end else if (accept) begin
			if (pred.last) begin
				kept_q <= '0;
			end else if (take) begin
				kept_q <= next_box;
			end
		end
	end

	// Hold the chosen box until the scaling stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && pred.last) begin
			valid_s1 <= 1'b1;
		end else if (box_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pred.last) begin
			box_s1 <= next_box;
		end
	end

	assign box_valid = valid_s1;
	assign box       = box_s1;

endmodule

FILE: hw/rtl/bdbs_scale.sv
// Pixel scaling of the chosen box: products, then truncation, saturation and window test.
`timescale 1ns / 1ps

module bdbs_scale (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdbs_pkg::cfg_t       cfg,
	input  logic                 box_valid,
	input  bdbs_pkg::box_t       box,
	output logic                 box_ready,
	bdbs_result_if.source        result
);

	localparam int NumW  = bdbs_pkg::CoordW + 3;
	localparam int ProdW = 32;
	localparam int CtrPW = bdbs_pkg::CoordW + bdbs_pkg::FrameW;
	localparam int CtrSW = CtrPW - 11;
	localparam int WinPW = bdbs_pkg::WinW + 15;

	logic signed [NumW-1:0]  lx_num, rx_num, ty_num, by_num;
	logic signed [bdbs_pkg::FrameW:0] fw_s, fh_s;

	logic                    valid_s2;
	logic signed [ProdW-1:0] left_p_s2, right_p_s2, top_p_s2, bottom_p_s2;
	logic [CtrPW-1:0]        cx_p_s2, cy_p_s2;
	logic [bdbs_pkg::ScoreW-1:0] score_s2;
	logic                    found_s2;

	logic                    valid_q;
	logic                    found_q;
	logic signed [bdbs_pkg::EdgeW-1:0] left_q, top_q, right_q, bottom_q;
	logic [bdbs_pkg::CenterW-1:0]      cx_q, cy_q;
	logic [bdbs_pkg::ScoreW-1:0]       score_q;
	logic                    aligned_q;
	logic                    out_ready;
	logic                    aligned_c;

	// Truncate a Q.16 pixel product toward zero and clamp to the edge range
	function automatic logic signed [bdbs_pkg::EdgeW-1:0] edge_px(
		input logic signed [ProdW-1:0] p
	);
		logic signed [ProdW-1:0] t;
		if (p < 0) begin
			t = (p + 32'sd65535) >>> 16;
		end else begin
			t = p >>> 16;
		end
		if (t > 32'sd16383) begin
			edge_px = 15'sd16383;
		end else if (t < -32'sd16384) begin
			edge_px = -15'sd16384;
		end else begin
			edge_px = t[bdbs_pkg::EdgeW-1:0];
		end
	endfunction

	// Clamp a centre product to pixels with four fraction bits
	function automatic logic [bdbs_pkg::CenterW-1:0] center_px(input logic [CtrPW-1:0] p);
		logic [CtrSW-1:0] v;
		v = p[CtrPW-1:11];
		if (v[CtrSW-1]) begin
			center_px = '1;
		end else begin
			center_px = v[bdbs_pkg::CenterW-1:0];
		end
	endfunction

	assign out_ready = !valid_q || result.ready;
	assign box_ready = !valid_s2 || out_ready;

	// Form twice centre plus or minus size, in Q.16
	always_comb begin
		lx_num = $signed({2'b00, box.x, 1'b0}) - $signed({3'b000, box.w});
		rx_num = $signed({2'b00, box.x, 1'b0}) + $signed({3'b000, box.w});
		ty_num = $signed({2'b00, box.y, 1'b0}) - $signed({3'b000, box.h});
		by_num = $signed({2'b00, box.y, 1'b0}) + $signed({3'b000, box.h});
		fw_s   = $signed({1'b0, cfg.frame_width});
		fh_s   = $signed({1'b0, cfg.frame_height});
	end

	// Advance the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (box_ready) begin
			valid_s2 <= box_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (box_ready && box_valid) begin
			left_p_s2   <= ProdW'(lx_num * fw_s);
			right_p_s2  <= ProdW'(rx_num * fw_s);
			top_p_s2    <= ProdW'(ty_num * fh_s);
			bottom_p_s2 <= ProdW'(by_num * fh_s);
			cx_p_s2     <= box.x * cfg.frame_width;
			cy_p_s2     <= box.y * cfg.frame_height;
			score_s2    <= box.score;
			found_s2    <= box.found;
		end
	end

	// Exact window test on the unrounded centre
	assign aligned_c = (cx_p_s2 > CtrPW'({cfg.window_low, 15'b0})) &&
		(cx_p_s2 < CtrPW'({cfg.window_high, 15'b0}));

	// Advance the result register; an empty frame gives all zero fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			found_q   <= found_s2;
			left_q    <= found_s2 ? edge_px(left_p_s2) : '0;
			right_q   <= found_s2 ? edge_px(right_p_s2) : '0;
			top_q     <= found_s2 ? edge_px(top_p_s2) : '0;
			bottom_q  <= found_s2 ? edge_px(bottom_p_s2) : '0;
			cx_q      <= found_s2 ? center_px(cx_p_s2) : '0;
			cy_q      <= found_s2 ? center_px(cy_p_s2) : '0;
			score_q   <= found_s2 ? score_s2 : '0;
			aligned_q <= found_s2 && aligned_c;
		end
	end

	assign result.valid       = valid_q;
	assign result.found       = found_q;
	assign result.left        = left_q;
	assign result.top         = top_q;
	assign result.right       = right_q;
	assign result.bottom      = bottom_q;
	assign result.center_x_q4 = cx_q;
	assign result.center_y_q4 = cy_q;
	assign result.best_score  = score_q;
	assign result.aligned     = aligned_q;

endmodule

FILE: hw/rtl/best_detection_box_select.sv
// Top level: configuration registers, frame selection and pixel scaling.
// Throughput: one prediction word per cycle; ready drops only when all stages hold results
// and result.ready is low. The chosen box passes the select, product and result registers.
// The score compare sets the per-word rate; the 19x14 multipliers sit in their own stage.
// Reset clears the registers to their defaults, the running selection and all valid flags.
`timescale 1ns / 1ps

module best_detection_box_select (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [bdbs_pkg::CfgIdxW-1:0]    wr_index,
	input  logic [bdbs_pkg::CfgDataW-1:0]   wr_data,
	bdbs_pred_if.sink                       pred,
	bdbs_result_if.source                   result
);

	bdbs_pkg::cfg_t cfg_q;
	bdbs_pkg::box_t box;
	logic           box_valid;
	logic           box_ready;

	// Write configuration registers, masked to their widths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= bdbs_pkg::ThresholdReset;
			cfg_q.frame_width     <= bdbs_pkg::FrameWidthReset;
			cfg_q.frame_height    <= bdbs_pkg::FrameHeightReset;
			cfg_q.window_low      <= bdbs_pkg::WindowLowReset;
			cfg_q.window_high     <= bdbs_pkg::WindowHighReset;
		end else if (wr_en) begin
			case (bdbs_pkg::cfg_reg_t'(wr_index))
				bdbs_pkg::REG_SCORE_THRESHOLD: begin
					cfg_q.score_threshold <= wr_data;
				end
				bdbs_pkg::REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= wr_data[bdbs_pkg::FrameW-1:0];
				end
				bdbs_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= wr_data[bdbs_pkg::FrameW-1:0];
				end
				bdbs_pkg::REG_WINDOW_LOW: begin
					cfg_q.window_low <= wr_data[bdbs_pkg::WinW-1:0];
				end
				bdbs_pkg::REG_WINDOW_HIGH: begin
					cfg_q.window_high <= wr_data[bdbs_pkg::WinW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	bdbs_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pred      (pred),
		.box_valid (box_valid),
		.box       (box),
		.box_ready (box_ready)
	);

	bdbs_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.box_valid (box_valid),
		.box       (box),
		.box_ready (box_ready),
		.result    (result)
	);

endmodule

FILE: hw/rtl/bdbs_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module bdbs_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                res_valid,
	input logic                                res_ready,
	input logic                                res_found,
	input logic signed [bdbs_pkg::EdgeW-1:0]   res_left,
	input logic signed [bdbs_pkg::EdgeW-1:0]   res_top,
	input logic signed [bdbs_pkg::EdgeW-1:0]   res_right,
	input logic signed [bdbs_pkg::EdgeW-1:0]   res_bottom,
	input logic [bdbs_pkg::CenterW-1:0]        res_cx,
	input logic [bdbs_pkg::CenterW-1:0]        res_cy,
	input logic [bdbs_pkg::ScoreW-1:0]         res_score,
	input logic                                res_aligned
);

	// Hold a stalled result word
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_left) && $stable(res_right) &&
			$stable(res_score) && $stable(res_found))
		else $error("stalled result word changed");

	// An empty frame reports all zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_left == 0 && res_top == 0 && res_right == 0 &&
			res_bottom == 0 && res_cx == 0 && res_cy == 0 && res_score == 0 && !res_aligned)
		else $error("empty frame result not zero");

	// Edges of a found box stay ordered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_found |-> res_left <= res_right && res_top <= res_bottom)
		else $error("box edges out of order");

endmodule

bind best_detection_box_select bdbs_checker u_bdbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_found   (result.found),
	.res_left    (result.left),
	.res_top     (result.top),
	.res_right   (result.right),
	.res_bottom  (result.bottom),
	.res_cx      (result.center_x_q4),
	.res_cy      (result.center_y_q4),
	.res_score   (result.best_score),
	.res_aligned (result.aligned)
);
